// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the line assembler.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define KLA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define KLA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/kla_pkg.sv -----
// ----------------------------------------------------------------------------
// kla_pkg
// Types, constants and the key code translation of the line assembler.
// ----------------------------------------------------------------------------
package kla_pkg;

    // Bytes in one line bank; the store holds two banks.
    localparam int LINE_LIMIT = 1024;
    localparam int LEN_W      = $clog2(LINE_LIMIT + 1);
    localparam int STORE_DEPTH = 2 * LINE_LIMIT;
    localparam int ADDR_W     = $clog2(STORE_DEPTH);
    localparam int IDX_W      = 10;
    localparam int CMP_W      = (LEN_W > IDX_W) ? LEN_W : IDX_W;
    localparam int OUT_LEN_W  = 11;

    typedef enum logic [1:0] {
        ACT_KEY     = 2'd0,
        ACT_READ    = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_CLEAR   = 2'd3
    } t_action;

    localparam logic [4:0] EV_KEY     = 5'd1;
    localparam logic [1:0] KV_RELEASE = 2'd0;
    localparam logic [7:0] KC_ENTER   = 8'd28;
    localparam logic [7:0] KC_LSHIFT  = 8'd42;
    localparam logic [7:0] CH_CR      = 8'h0D;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic [7:0]       ch;
        logic             cvalid;
        logic             commit;
        logic             ovf;
        logic             rd_hit;
        logic             rdy;
        logic [LEN_W-1:0] len;
    } t_result;

    // Scan code to ASCII; letters are stored in lower case and flipped by shift.
    function automatic logic [7:0] map_key(input logic [7:0] code, input logic sh);
        logic [7:0] letter;
        logic [7:0] res;
        letter = 8'h00;
        res    = code;
        case (code)
            8'd16: letter = "q";
            8'd17: letter = "w";
            8'd18: letter = "e";
            8'd19: letter = "r";
            8'd20: letter = "t";
            8'd21: letter = "y";
            8'd22: letter = "u";
            8'd23: letter = "i";
            8'd24: letter = "o";
            8'd25: letter = "p";
            8'd30: letter = "a";
            8'd31: letter = "s";
            8'd32: letter = "d";
            8'd33: letter = "f";
            8'd34: letter = "g";
            8'd35: letter = "h";
            8'd36: letter = "j";
            8'd37: letter = "k";
            8'd38: letter = "l";
            8'd44: letter = "z";
            8'd45: letter = "x";
            8'd46: letter = "c";
            8'd47: letter = "v";
            8'd48: letter = "b";
            8'd49: letter = "n";
            8'd50: letter = "m";
            default: letter = 8'h00;
        endcase
        case (code)
            8'd2:   res = sh ? "!" : "1";
            8'd3:   res = sh ? "@" : "2";
            8'd4:   res = sh ? "#" : "3";
            8'd5:   res = sh ? "$" : "4";
            8'd6:   res = sh ? "%" : "5";
            8'd7:   res = sh ? "^" : "6";
            8'd8:   res = sh ? "&" : "7";
            8'd9:   res = sh ? "*" : "8";
            8'd10:  res = sh ? "(" : "9";
            8'd11:  res = sh ? ")" : "0";
            8'd13:  res = sh ? "+" : "=";
            8'd39:  res = sh ? ":" : ";";
            8'd53:  res = sh ? "?" : "/";
            8'd52:  res = ".";
            8'd74:  res = "-";
            8'd78:  res = "+";
            8'd108: res = 8'hFE;
            KC_ENTER: res = CH_CR;
            default: res = (letter != 8'h00) ? (sh ? (letter ^ 8'h20) : letter) : code;
        endcase
        return res;
    endfunction

endpackage

// ----- sv/kla_if.sv -----
// ----------------------------------------------------------------------------
// kla_in_if / kla_out_if
// Valid/ready channels carrying requests into and results out of the block.
// ----------------------------------------------------------------------------
interface kla_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [4:0] event_type;
    logic [9:0] key_code;
    logic [1:0] key_value;
    logic [9:0] read_index;

    modport source (output valid, action, event_type, key_code, key_value, read_index,
                    input ready);
    modport sink   (input valid, action, event_type, key_code, key_value, read_index,
                    output ready);
endinterface

interface kla_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_out;
    logic        char_valid;
    logic        line_committed;
    logic        line_overflow;
    logic [7:0]  code_byte;
    logic        code_ready;
    logic [10:0] code_length;

    modport source (output valid, char_out, char_valid, line_committed, line_overflow,
                    code_byte, code_ready, code_length, input ready);
    modport sink   (input valid, char_out, char_valid, line_committed, line_overflow,
                    code_byte, code_ready, code_length, output ready);
endinterface

// ----- sv/kla_line_ram.sv -----
// ----------------------------------------------------------------------------
// kla_line_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read that holds its data while no read is enabled.
// ----------------------------------------------------------------------------
module kla_line_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/kla_ctrl.sv -----
// ----------------------------------------------------------------------------
// kla_ctrl
// Request decoder and line state: translates key releases, appends to the
// active bank, swaps banks on enter and issues reads of the completed bank.
// ----------------------------------------------------------------------------
module kla_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_action,
    input  logic [4:0]         i_event_type,
    input  logic [9:0]         i_key_code,
    input  logic [1:0]         i_key_value,
    input  logic [9:0]         i_read_index,
    output kla_pkg::t_mem_req  o_mem,
    output kla_pkg::t_result   o_res
);
    import kla_pkg::*;

    localparam logic [ADDR_W-1:0] BANK1_BASE = ADDR_W'(LINE_LIMIT);
    localparam logic [LEN_W-1:0]  LEN_LIMIT  = LEN_W'(LINE_LIMIT);

    logic             r_bank, n_bank;
    logic [LEN_W-1:0] r_line_len, n_line_len;
    logic [LEN_W-1:0] r_done_len, n_done_len;
    logic             r_done_ready, n_done_ready;
    logic             r_shift, n_shift;
    logic             r_first_nz, n_first_nz;

    t_action          act;
    logic [7:0]       code;
    logic             key_rel;
    logic             rd_hit;
    logic [7:0]       ch;
    t_mem_req         mem;
    t_result          res;

    assign act     = t_action'(i_action);
    assign code    = i_key_code[7:0];
    assign key_rel = (i_event_type == EV_KEY) && (i_key_value == KV_RELEASE);
    assign rd_hit  = CMP_W'(i_read_index) < CMP_W'(r_done_len);
    assign ch      = map_key(code, r_shift);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank       <= 1'b0;
            r_line_len   <= '0;
            r_done_len   <= '0;
            r_done_ready <= 1'b0;
            r_shift      <= 1'b0;
            r_first_nz   <= 1'b0;
        end else if (i_accept) begin
            r_bank       <= n_bank;
            r_line_len   <= n_line_len;
            r_done_len   <= n_done_len;
            r_done_ready <= n_done_ready;
            r_shift      <= n_shift;
            r_first_nz   <= n_first_nz;
        end
    end

    always_comb begin
        n_bank       = r_bank;
        n_line_len   = r_line_len;
        n_done_len   = r_done_len;
        n_done_ready = r_done_ready;
        n_shift      = r_shift;
        n_first_nz   = r_first_nz;
        mem          = '0;
        res          = '0;
        mem.waddr    = (r_bank ? BANK1_BASE : '0) + ADDR_W'(r_line_len);
        mem.wdata    = ch;
        mem.raddr    = (r_bank ? '0 : BANK1_BASE) + ADDR_W'(i_read_index);
        case (act)
            ACT_KEY: begin
                if (key_rel) begin
                    if (code == KC_LSHIFT) begin
                        n_shift = 1'b1;
                    end else begin
                        n_shift    = 1'b0;
                        res.ch     = ch;
                        res.cvalid = 1'b1;
                        if (code == KC_ENTER) begin
                            n_done_len   = r_line_len;
                            n_done_ready = (r_line_len != '0) && r_first_nz;
                            n_bank       = ~r_bank;
                            n_line_len   = '0;
                            res.commit   = 1'b1;
                        end else if (r_line_len >= LEN_LIMIT) begin
                            n_line_len = '0;
                            res.ovf    = 1'b1;
                        end else begin
                            mem.we     = 1'b1;
                            n_line_len = r_line_len + LEN_W'(1);
                            if (r_line_len == '0) begin
                                n_first_nz = (ch != 8'h00);
                            end
                        end
                    end
                end
                res.rdy = n_done_ready;
                res.len = n_done_len;
            end
            ACT_READ: begin
                mem.re     = 1'b1;
                res.rd_hit = rd_hit;
                res.rdy    = r_done_ready;
                res.len    = r_done_len;
            end
            ACT_RELEASE: begin
                if (r_done_ready) begin
                    mem.re       = 1'b1;
                    res.rd_hit   = rd_hit;
                    res.rdy      = 1'b1;
                    res.len      = r_done_len;
                    n_done_ready = 1'b0;
                    n_done_len   = '0;
                end
            end
            ACT_CLEAR: begin
                n_line_len   = '0;
                n_done_len   = '0;
                n_done_ready = 1'b0;
            end
            default: begin
                res = '0;
            end
        endcase
        mem.we = mem.we & i_accept;
        mem.re = mem.re & i_accept;
    end

    assign o_mem = mem;
    assign o_res = res;

`include "assert_macros.svh"

    `KLA_ASSERT(a_no_rw_overlap, !(mem.we && mem.re), "line store read and written together")
    `KLA_ASSERT(a_line_bound, r_line_len <= LEN_LIMIT, "line length beyond the bank size")
    `KLA_ASSERT(a_ready_len, r_done_ready |-> (r_done_len != '0), "ready code of zero length")
    `KLA_ASSERT(a_bank_swap, (i_accept && res.commit) |=> (r_bank != $past(r_bank)), "enter without bank swap")
endmodule

// ----- sv/keycode_line_assembler_core.sv -----
// ----------------------------------------------------------------------------
// keycode_line_assembler_core
// Builds text lines from scanner key releases in a two-bank line store and
// serves reads of the completed line.
// ----------------------------------------------------------------------------
// Each request gets exactly one result. When a request is taken, the line
// state is updated at once and any read of the line store is issued to the
// single-port-read RAM, whose data arrive after the next clock edge. At that
// edge the result moves into the first stage, and it passes on into the
// output register with the read data once that register is free. A new request can be taken every cycle
// as long as results are drained; while a result waits at the output, one
// more request is taken into the first stage and the input is then held until
// the output is read. The line store needs no clearing pass after reset,
// since only bytes that were written are read.
module keycode_line_assembler_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    kla_in_if.sink   i_in,
    kla_out_if.source o_out
);
    import kla_pkg::*;

    t_mem_req   mem;
    t_result    res;
    logic [7:0] rdata;
    logic       accept;
    logic       s1_adv;

    logic       r_s1_valid;
    t_result    r_s1;
    logic       r_out_valid;
    logic [7:0] r_char_out;
    logic       r_char_valid;
    logic       r_committed;
    logic       r_overflow;
    logic [7:0] r_code_byte;
    logic       r_code_ready;
    logic [OUT_LEN_W-1:0] r_code_length;

    // A result in the first stage moves on whenever the output register frees.
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign accept     = i_in.valid && i_in.ready;

    kla_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_action     (i_in.action),
        .i_event_type (i_in.event_type),
        .i_key_code   (i_in.key_code),
        .i_key_value  (i_in.key_value),
        .i_read_index (i_in.read_index),
        .o_mem        (mem),
        .o_res        (res)
    );

    kla_line_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= res;
        end
        if (s1_adv) begin
            r_char_out    <= r_s1.ch;
            r_char_valid  <= r_s1.cvalid;
            r_committed   <= r_s1.commit;
            r_overflow    <= r_s1.ovf;
            r_code_byte   <= r_s1.rd_hit ? rdata : 8'h00;
            r_code_ready  <= r_s1.rdy;
            r_code_length <= OUT_LEN_W'(r_s1.len);
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.char_out       = r_char_out;
    assign o_out.char_valid     = r_char_valid;
    assign o_out.line_committed = r_committed;
    assign o_out.line_overflow  = r_overflow;
    assign o_out.code_byte      = r_code_byte;
    assign o_out.code_ready     = r_code_ready;
    assign o_out.code_length    = r_code_length;
endmodule

// ----- sim/kla_line_checker.sv -----
// ----------------------------------------------------------------------------
// kla_line_checker
// Watches the request and result channels of the line assembler, keeps its
// own copy of the line banks and completed-code state, and compares every
// result with the one predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module kla_line_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    kla_in_if    i_req,
    kla_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_commits,
    output int   o_overflows
);
    import kla_pkg::*;

    typedef struct packed {
        logic [7:0]  ch;
        logic        cvalid;
        logic        commit;
        logic        ovf;
        logic [7:0]  cbyte;
        logic        rdy;
        logic [10:0] len;
    } t_line_result;

    localparam logic [79:0] TOP_ROW         = "qwertyuiop";
    localparam logic [79:0] HOME_ROW        = "asdfghjkl";
    localparam logic [79:0] BOTTOM_ROW      = "zxcvbnm";
    localparam logic [79:0] DIGIT_ROW       = "1234567890";
    localparam logic [79:0] DIGIT_SHIFT_ROW = "!@#$%^&*()";

    logic [7:0]   line_bytes [0:2*LINE_LIMIT-1];
    logic         bank_sel;
    logic [10:0]  cur_len;
    logic [10:0]  code_len;
    logic         code_valid;
    logic         shift_armed;
    t_line_result line_results_due [$];

    // Rows are packed with their first character in the highest used byte.
    function automatic logic [7:0] row_char(input logic [79:0] row, input int row_len,
                                            input int pos);
        return row[8*(row_len-1-pos) +: 8];
    endfunction

    function automatic logic [7:0] key_to_ascii(input logic [7:0] code, input logic shifted);
        logic [7:0] letter;
        if (code >= 8'd2 && code <= 8'd11) begin
            return shifted ? row_char(DIGIT_SHIFT_ROW, 10, code - 2)
                           : row_char(DIGIT_ROW, 10, code - 2);
        end
        letter = 8'h00;
        if (code >= 8'd16 && code <= 8'd25) letter = row_char(TOP_ROW, 10, code - 16);
        if (code >= 8'd30 && code <= 8'd38) letter = row_char(HOME_ROW, 9, code - 30);
        if (code >= 8'd44 && code <= 8'd50) letter = row_char(BOTTOM_ROW, 7, code - 44);
        if (letter != 8'h00) begin
            return shifted ? letter - 8'h20 : letter;
        end
        case (code)
            8'd13:    return shifted ? "+" : "=";
            8'd39:    return shifted ? ":" : ";";
            8'd53:    return shifted ? "?" : "/";
            8'd52:    return ".";
            8'd74:    return "-";
            8'd78:    return "+";
            8'd108:   return 8'hFE;
            KC_ENTER: return CH_CR;
            default:  return code;
        endcase
    endfunction

    // Byte of the completed line; anything at or past its length reads as zero.
    function automatic logic [7:0] stored_byte(input logic [9:0] idx);
        if ({1'b0, idx} >= code_len) return 8'h00;
        return line_bytes[(bank_sel ? 0 : LINE_LIMIT) + idx];
    endfunction

    task automatic predict_line_step(input t_action act, input logic [4:0] etype,
                                     input logic [9:0] key, input logic [1:0] kval,
                                     input logic [9:0] ridx, output t_line_result res);
        logic [7:0] code;
        int         base;
        code = key[7:0];
        base = bank_sel ? LINE_LIMIT : 0;
        res  = '0;
        case (act)
            ACT_KEY: begin
                if (etype == EV_KEY && kval == KV_RELEASE) begin
                    if (code == KC_LSHIFT) begin
                        shift_armed = 1'b1;
                    end else begin
                        res.ch      = key_to_ascii(code, shift_armed);
                        res.cvalid  = 1'b1;
                        shift_armed = 1'b0;
                        if (code == KC_ENTER) begin
                            code_len   = cur_len;
                            code_valid = (cur_len != 0) && (line_bytes[base] != 8'h00);
                            bank_sel   = ~bank_sel;
                            cur_len    = '0;
                            res.commit = 1'b1;
                        end else if (cur_len >= LINE_LIMIT) begin
                            cur_len = '0;
                            res.ovf = 1'b1;
                        end else begin
                            line_bytes[base + cur_len] = res.ch;
                            cur_len = cur_len + 11'd1;
                        end
                    end
                end
                res.rdy = code_valid;
                res.len = code_len;
            end
            ACT_READ: begin
                res.cbyte = stored_byte(ridx);
                res.rdy   = code_valid;
                res.len   = code_len;
            end
            ACT_RELEASE: begin
                // Releasing with nothing ready changes nothing and reports zeros.
                if (code_valid) begin
                    res.cbyte  = stored_byte(ridx);
                    res.rdy    = 1'b1;
                    res.len    = code_len;
                    code_valid = 1'b0;
                    code_len   = '0;
                end
            end
            default: begin
                cur_len    = '0;
                code_len   = '0;
                code_valid = 1'b0;
            end
        endcase
    endtask

    task automatic check_field(input string field, input logic [10:0] want,
                               input logic [10:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_line_result want;
        if (!i_rst_n) begin
            bank_sel     = 1'b0;
            cur_len      = '0;
            code_len     = '0;
            code_valid   = 1'b0;
            shift_armed  = 1'b0;
            o_fail_count = 0;
            o_checked    = 0;
            o_commits    = 0;
            o_overflows  = 0;
            line_results_due.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                predict_line_step(t_action'(i_req.action), i_req.event_type, i_req.key_code,
                                  i_req.key_value, i_req.read_index, want);
                line_results_due.push_back(want);
            end
            if (i_res.valid && i_res.ready) begin
                if (line_results_due.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = line_results_due.pop_front();
                    check_field("char_out", 11'(want.ch), 11'(i_res.char_out));
                    check_field("char_valid", 11'(want.cvalid), 11'(i_res.char_valid));
                    check_field("line_committed", 11'(want.commit),
                                11'(i_res.line_committed));
                    check_field("line_overflow", 11'(want.ovf), 11'(i_res.line_overflow));
                    check_field("code_byte", 11'(want.cbyte), 11'(i_res.code_byte));
                    check_field("code_ready", 11'(want.rdy), 11'(i_res.code_ready));
                    check_field("code_length", want.len, i_res.code_length);
                    o_checked++;
                    if (want.commit) o_commits++;
                    if (want.ovf) o_overflows++;
                end
            end
        end
        o_pending = line_results_due.size();
    end

endmodule

// ----- sim/keycode_line_assembler_core_tb.sv -----
// ----------------------------------------------------------------------------
// keycode_line_assembler_core_tb
// Drives scanner key events, reads and releases of the completed line into
// the line assembler with random gaps and result stalls, and lets the
// checker beside the block judge every result.
// ----------------------------------------------------------------------------
module keycode_line_assembler_core_tb;
    import kla_pkg::*;

    localparam logic [1:0] KV_PRESS      = 2'd1;
    localparam logic [1:0] KV_REPEAT     = 2'd2;
    localparam logic [9:0] KEY_ENTER     = {2'b00, KC_ENTER};
    localparam logic [9:0] KEY_LSHIFT    = {2'b00, KC_LSHIFT};
    localparam int         SHORT_LINE_REQUESTS = 100;
    localparam int         TAIL_CYCLES   = 8;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending_results;
    int   checked_results;
    int   commit_count;
    int   overflow_count;
    int   sent_count;
    int   acted_count;
    bit   steady_send;
    bit   steady_sink;

    kla_in_if  req_ch ();
    kla_out_if res_ch ();

    keycode_line_assembler_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    kla_line_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_results),
        .o_checked    (checked_results),
        .o_commits    (commit_count),
        .o_overflows  (overflow_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("keycode_line_assembler_core verification failed");
        $finish;
    end

    // Mostly back to back, otherwise a short gap or, now and then, a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial begin
        int run;
        int stall;
        res_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            steady_sink = ($urandom_range(0, 9) == 0);
            run = steady_sink ? $urandom_range(50, 200) : $urandom_range(1, 12);
            res_ch.ready = 1'b1;
            repeat (run) @(negedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
        end
    end

    task automatic send_request(input t_action act, input logic [4:0] etype,
                                input logic [9:0] key, input logic [1:0] kval,
                                input logic [9:0] ridx);
        int gap;
        gap = steady_send ? 0 : pick_gap();
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.action     = act;
        req_ch.event_type = etype;
        req_ch.key_code   = key;
        req_ch.key_value  = kval;
        req_ch.read_index = ridx;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
        if (act != ACT_KEY || (etype == EV_KEY && kval == KV_RELEASE)) acted_count++;
    endtask

    task automatic press_key(input logic [9:0] key);
        send_request(ACT_KEY, EV_KEY, key, KV_RELEASE, 10'($urandom_range(0, 1023)));
    endtask

    task automatic read_code(input logic [9:0] idx);
        send_request(ACT_READ, 5'($urandom_range(0, 31)), 10'($urandom_range(0, 767)),
                     2'($urandom_range(0, 2)), idx);
    endtask

    task automatic release_code(input logic [9:0] idx);
        send_request(ACT_RELEASE, 5'($urandom_range(0, 31)), 10'($urandom_range(0, 767)),
                     2'($urandom_range(0, 2)), idx);
    endtask

    task automatic clear_all();
        send_request(ACT_CLEAR, 5'($urandom_range(0, 31)), 10'($urandom_range(0, 767)),
                     2'($urandom_range(0, 2)), 10'($urandom_range(0, 1023)));
    endtask

    // A key event the block has to ignore: wrong type, or a press or repeat.
    task automatic send_ignored();
        logic [4:0] etype;
        logic [1:0] kval;
        etype = 5'($urandom_range(0, 31));
        kval  = 2'($urandom_range(0, 2));
        if (etype == EV_KEY && kval == KV_RELEASE) kval = ($urandom_range(0, 1)) ? KV_PRESS
                                                                                  : KV_REPEAT;
        send_request(ACT_KEY, etype, 10'($urandom_range(0, 767)), kval,
                     10'($urandom_range(0, 1023)));
    endtask

    task automatic send_noise();
        t_action act;
        act = ($urandom_range(0, 99) < 70) ? ACT_KEY : t_action'($urandom_range(0, 3));
        send_request(act, 5'($urandom_range(0, 31)), 10'($urandom_range(0, 767)),
                     2'($urandom_range(0, 2)), 10'($urandom_range(0, 1023)));
    endtask

    // Line content: never enter or shift, mostly mapped keys.
    function automatic logic [9:0] pick_line_code();
        logic [9:0] key;
        int         r;
        do begin
            r = $urandom_range(0, 99);
            if (r < 75) key = 10'($urandom_range(2, 53));
            else if (r < 78) key = 74;
            else if (r < 81) key = 78;
            else if (r < 84) key = 108;
            else key = 10'($urandom_range(0, 767));
        end while (key[7:0] == KC_ENTER || key[7:0] == KC_LSHIFT);
        return key;
    endfunction

    task automatic type_line(input int n, input bit with_noise);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 15) press_key(KEY_LSHIFT);
            if (with_noise && $urandom_range(0, 99) < 8) send_ignored();
            press_key(pick_line_code());
        end
    endtask

    task automatic pick_index(input int n, output logic [9:0] idx);
        if (n > 0 && $urandom_range(0, 99) < 60) idx = 10'($urandom_range(0, n - 1));
        else idx = 10'($urandom_range(0, 1023));
    endtask

    task automatic wait_idle();
        req_ch.valid = 1'b0;
        while (pending_results != 0) @(negedge i_clk);
    endtask

    initial begin
        int         start;
        int         n;
        int         r;
        logic [9:0] idx;
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_KEY;
        req_ch.event_type = '0;
        req_ch.key_code   = '0;
        req_ch.key_value  = '0;
        req_ch.read_index = '0;
        steady_send       = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Shifted digit, ignored events, the odd mappings and a high key code.
        press_key(KEY_LSHIFT);
        press_key(3);
        send_request(ACT_KEY, 5'd31, 16, KV_RELEASE, 0);
        send_request(ACT_KEY, EV_KEY, 16, KV_PRESS, 1023);
        send_request(ACT_KEY, EV_KEY, 16, KV_REPEAT, 0);
        press_key(767);
        press_key(108);
        press_key(52);
        press_key(13);
        press_key(KEY_LSHIFT);
        press_key(13);
        press_key(KEY_ENTER);
        read_code(0);
        read_code(1023);
        release_code(3);
        release_code(0);
        // An empty line, then a line whose first byte is zero.
        press_key(KEY_ENTER);
        press_key(256);
        press_key(30);
        press_key(KEY_ENTER);
        read_code(1);
        release_code(1);
        // Shift pressed twice stays armed and survives a clear.
        press_key(KEY_LSHIFT);
        press_key(KEY_LSHIFT);
        clear_all();
        press_key(16);
        wait_idle();

        // A line of exactly the bank size, committed and read at its last byte.
        clear_all();
        for (int i = 0; i < LINE_LIMIT; i++) begin
            if (i % 128 == 0) steady_send = ($urandom_range(0, 3) == 0);
            press_key(pick_line_code());
        end
        press_key(KEY_ENTER);
        read_code(10'(LINE_LIMIT - 1));
        read_code(0);
        read_code(10'($urandom_range(0, 1023)));
        release_code(10'(LINE_LIMIT - 1));
        wait_idle();

        // One character more than the bank holds throws the line away.
        for (int i = 0; i <= LINE_LIMIT; i++) begin
            if (i % 128 == 0) steady_send = ($urandom_range(0, 3) == 0);
            press_key(pick_line_code());
        end
        type_line(3, 1'b0);
        press_key(KEY_ENTER);
        read_code(2);
        wait_idle();

        start = acted_count;
        while (acted_count - start < SHORT_LINE_REQUESTS) begin
            steady_send = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            if (r < 60) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
                type_line(n, 1'b1);
                if ($urandom_range(0, 99) < 10) press_key(KEY_LSHIFT);
                if ($urandom_range(0, 99) < 90) press_key(KEY_ENTER);
                repeat ($urandom_range(0, 4)) begin
                    pick_index(n, idx);
                    read_code(idx);
                end
                if ($urandom_range(0, 99) < 60) begin
                    pick_index(n, idx);
                    release_code(idx);
                end
            end else if (r < 75) begin
                repeat ($urandom_range(1, 6)) send_noise();
            end else if (r < 85) begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 1)) read_code(10'($urandom_range(0, 1023)));
                    else release_code(10'($urandom_range(0, 1023)));
                end
            end else if (r < 92) begin
                clear_all();
            end else begin
                wait_idle();
            end
        end

        steady_send = 1'b0;
        wait_idle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("Sent %0d requests, %0d of them acted on; checked %0d results.",
                 sent_count, acted_count, checked_results);
        $display("Lines committed: %0d; lines discarded for length: %0d.",
                 commit_count, overflow_count);
        if (fail_count == 0) begin
            $display("keycode_line_assembler_core verification clean");
        end else begin
            $display("keycode_line_assembler_core verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/kla_pkg.sv
sv/kla_if.sv
sv/kla_line_ram.sv
sv/kla_ctrl.sv
sv/keycode_line_assembler_core.sv
sim/kla_line_checker.sv
sim/keycode_line_assembler_core_tb.sv
